/* src/tcb_pkg.sv */
// Shared types and constants for the text console buffer.
// No dependencies; compiled first.
`default_nettype none

package tcb_pkg;

  localparam int CODE_W = 8;
  localparam int IDX_W  = 11;
  localparam int OP_W   = 3;

  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CODE_W-1:0] CH_TILDE     = 8'd126;

  localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_PUT     = 3'd2;
  localparam logic [OP_W-1:0] OP_NEWLINE = 3'd3;
  localparam logic [OP_W-1:0] OP_BKSP    = 3'd4;
  localparam logic [OP_W-1:0] OP_SUBMIT  = 3'd5;

  // classified word as it sits in the front queue
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  read_index;
  } tcb_op_t;

endpackage

`default_nettype wire

/* src/tcb_channels.sv */
// Valid/ready channel interfaces for the console buffer input and result words.
// Depends on tcb_pkg for field widths.
`default_nettype none

interface tcb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [tcb_pkg::CODE_W-1:0]  char_code;
  logic [tcb_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, cmd, char_code, read_index, input ready);
  modport sink   (input valid, cmd, char_code, read_index, output ready);
endinterface

interface tcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcb_pkg::CODE_W-1:0]  cell_value;
  logic [tcb_pkg::IDX_W-1:0]   cursor_index;
  logic                        scrolled;
  logic                        submitted;
  logic [tcb_pkg::IDX_W-1:0]   submit_length;

  modport source (output valid, cell_value, cursor_index, scrolled, submitted, submit_length,
                  input ready);
  modport sink   (input valid, cell_value, cursor_index, scrolled, submitted, submit_length,
                  output ready);
endinterface

`default_nettype wire

/* src/tcb_front.sv */
// Front end: accepts input words, classifies them and queues them (two deep).
// Holds the submit_on_newline register. Depends on tcb_pkg and tcb_in_if.
`default_nettype none

module tcb_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic             hold,
  tcb_in_if.sink                in_word,
  output logic                  q_valid,
  output tcb_pkg::tcb_op_t      q_head,
  input  wire logic             q_pop
);

  logic             submit_on_newline;
  tcb_pkg::tcb_op_t entry;
  tcb_pkg::tcb_op_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             accept;

  assign in_word.ready = (count != 2'd2) && !hold;
  assign accept        = in_word.valid && in_word.ready;
  assign q_valid       = (count != 2'd0);
  assign q_head        = slots[rd_ptr];

  always_comb begin
    entry.code       = in_word.char_code;
    entry.read_index = in_word.read_index;
    if (in_word.cmd) begin
      entry.op = tcb_pkg::OP_READ;
    end else if (in_word.char_code == tcb_pkg::CH_NEWLINE) begin
      entry.op = submit_on_newline ? tcb_pkg::OP_SUBMIT : tcb_pkg::OP_NEWLINE;
    end else if (in_word.char_code == tcb_pkg::CH_BACKSPACE) begin
      entry.op = tcb_pkg::OP_BKSP;
    end else if (in_word.char_code >= tcb_pkg::CH_SPACE &&
                 in_word.char_code <= tcb_pkg::CH_TILDE) begin
      entry.op = tcb_pkg::OP_PUT;
    end else begin
      entry.op = tcb_pkg::OP_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      submit_on_newline <= 1'b0;
      wr_ptr            <= 1'b0;
      rd_ptr            <= 1'b0;
      count             <= 2'd0;
    end else begin
      if (cfg_we) begin
        submit_on_newline <= cfg_wdata;
      end
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

/* src/tcb_back.sv */
// Back end: owns the cell memory and cursor, executes queued words and
// registers one result word each. Depends on tcb_pkg and tcb_out_if.
`default_nettype none

module tcb_back #(
  parameter int ROW_WIDTH = 80,
  parameter int ROWS      = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire tcb_pkg::tcb_op_t q_head,
  output logic                  q_pop,
  output logic                  filling,
  tcb_out_if.source             out_word
);

  localparam int NCELLS = ROWS * ROW_WIDTH;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(ROW_WIDTH);
  localparam int DW     = tcb_pkg::CODE_W;
  localparam int IW     = tcb_pkg::IDX_W;

  localparam logic [AW:0]   N_EXT    = (AW+1)'(NCELLS);
  localparam logic [AW:0]   W_EXT    = (AW+1)'(ROW_WIDTH);
  localparam logic [AW-1:0] LAST_ROW = AW'(NCELLS - ROW_WIDTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(NCELLS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(ROW_WIDTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;

  logic [DW-1:0] mem [NCELLS];
  logic [DW-1:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [2:0]    state, state_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [CW-1:0] col, col_next;
  logic [AW:0]   fill_addr, fill_addr_next;
  logic [AW:0]   fill_end, fill_end_next;
  logic          fill_init, fill_init_next;
  logic [AW-1:0] scr_dst, scr_dst_next;
  logic          mv_pend, mv_pend_next;
  logic          mv_zero, mv_zero_next;
  logic [AW-1:0] mv_dst, mv_dst_next;
  logic          res_scrolled, res_scrolled_next;
  logic          res_submitted, res_submitted_next;
  logic [IW-1:0] res_len, res_len_next;
  logic          out_valid, out_valid_next;
  logic [DW-1:0] out_value;
  logic [IW-1:0] out_cursor;
  logic          out_scrolled;
  logic          out_submitted;
  logic [IW-1:0] out_len;

  logic          emit;
  logic [DW-1:0] emit_value;
  logic [AW:0]   put_next;
  logic [AW:0]   nl_next;
  logic [AW:0]   adv_next;
  logic [AW:0]   scr_src;
  logic          rd_in_range;

  assign put_next    = {1'b0, cursor} + (AW+1)'(1);
  // start of the next row: cursor minus column plus one row
  assign nl_next     = {1'b0, cursor} - (AW+1)'(col) + W_EXT;
  assign adv_next    = (q_head.op == tcb_pkg::OP_PUT) ? put_next : nl_next;
  assign scr_src     = {1'b0, scr_dst} + W_EXT;
  assign rd_in_range = (32'(q_head.read_index) < 32'(NCELLS));
  assign filling     = fill_init;

  assign out_word.valid         = out_valid;
  assign out_word.cell_value    = out_value;
  assign out_word.cursor_index  = out_cursor;
  assign out_word.scrolled      = out_scrolled;
  assign out_word.submitted     = out_submitted;
  assign out_word.submit_length = out_len;

  always_comb begin
    state_next         = state;
    cursor_next        = cursor;
    col_next           = col;
    fill_addr_next     = fill_addr;
    fill_end_next      = fill_end;
    fill_init_next     = fill_init;
    scr_dst_next       = scr_dst;
    mv_pend_next       = 1'b0;
    mv_zero_next       = mv_zero;
    mv_dst_next        = mv_dst;
    res_scrolled_next  = res_scrolled;
    res_submitted_next = res_submitted;
    res_len_next       = res_len;
    q_pop              = 1'b0;
    emit               = 1'b0;
    emit_value         = '0;
    mem_re             = 1'b0;
    mem_raddr          = '0;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = '0;

    // row move write-back, in the cycle after its read
    if (mv_pend) begin
      mem_we    = 1'b1;
      mem_waddr = mv_dst;
      mem_wdata = mv_zero ? '0 : rdata;
    end

    unique case (state)
      S_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop              = 1'b1;
          res_scrolled_next  = 1'b0;
          res_submitted_next = 1'b0;
          res_len_next       = '0;
          unique case (q_head.op) inside
            tcb_pkg::OP_READ: begin
              if (rd_in_range) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(q_head.read_index);
                state_next = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            tcb_pkg::OP_PUT, tcb_pkg::OP_NEWLINE: begin
              mem_we    = 1'b1;
              mem_waddr = cursor;
              mem_wdata = q_head.code;
              if (adv_next >= N_EXT) begin
                state_next        = S_SCROLL;
                scr_dst_next      = '0;
                cursor_next       = LAST_ROW;
                col_next          = '0;
                res_scrolled_next = 1'b1;
              end else begin
                cursor_next = adv_next[AW-1:0];
                if (q_head.op == tcb_pkg::OP_PUT && col != COL_LAST) begin
                  col_next = col + CW'(1);
                end else begin
                  col_next = '0;
                end
                emit = 1'b1;
              end
            end
            tcb_pkg::OP_BKSP: begin
              if (cursor != '0) begin
                mem_we      = 1'b1;
                mem_waddr   = cursor - AW'(1);
                cursor_next = cursor - AW'(1);
                if (col == '0) begin
                  // crossed a row boundary: wipe the row just left
                  col_next       = COL_LAST;
                  state_next     = S_FILL;
                  fill_addr_next = {1'b0, cursor};
                  fill_end_next  = {1'b0, cursor} + W_EXT;
                end else begin
                  col_next = col - CW'(1);
                  emit     = 1'b1;
                end
              end else begin
                emit = 1'b1;
              end
            end
            tcb_pkg::OP_SUBMIT: begin
              res_submitted_next = 1'b1;
              res_len_next       = IW'(cursor);
              cursor_next        = '0;
              col_next           = '0;
              if (cursor != '0) begin
                state_next     = S_FILL;
                fill_addr_next = '0;
                fill_end_next  = {1'b0, cursor};
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        emit       = 1'b1;
        emit_value = rdata;
        state_next = S_IDLE;
      end
      S_FILL: begin
        mem_we         = 1'b1;
        mem_waddr      = fill_addr[AW-1:0];
        fill_addr_next = fill_addr + (AW+1)'(1);
        if (fill_addr_next == fill_end) begin
          state_next = S_IDLE;
          if (fill_init) begin
            fill_init_next = 1'b0;
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        // source past the grid end feeds zeros into the last row
        if (scr_src < N_EXT) begin
          mem_re    = 1'b1;
          mem_raddr = scr_src[AW-1:0];
        end
        mv_pend_next = 1'b1;
        mv_zero_next = (scr_src >= N_EXT);
        mv_dst_next  = scr_dst;
        scr_dst_next = scr_dst + AW'(1);
        if (scr_dst == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_word.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      cursor        <= '0;
      col           <= '0;
      fill_addr     <= '0;
      fill_end      <= N_EXT;
      fill_init     <= 1'b1;
      scr_dst       <= '0;
      mv_pend       <= 1'b0;
      mv_zero       <= 1'b0;
      mv_dst        <= '0;
      res_scrolled  <= 1'b0;
      res_submitted <= 1'b0;
      res_len       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      cursor        <= cursor_next;
      col           <= col_next;
      fill_addr     <= fill_addr_next;
      fill_end      <= fill_end_next;
      fill_init     <= fill_init_next;
      scr_dst       <= scr_dst_next;
      mv_pend       <= mv_pend_next;
      mv_zero       <= mv_zero_next;
      mv_dst        <= mv_dst_next;
      res_scrolled  <= res_scrolled_next;
      res_submitted <= res_submitted_next;
      res_len       <= res_len_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value     <= emit_value;
      out_cursor    <= IW'(cursor_next);
      out_scrolled  <= res_scrolled_next;
      out_submitted <= res_submitted_next;
      out_len       <= res_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

/* src/text_console_buffer_core.sv */
// Each accepted word is registered in the front queue before the back end sees it; a read
// passes the memory read register and S_READ; a put or newline writes from S_IDLE;
// clears run in S_FILL and a scroll in S_SCROLL then S_DRAIN. A new word is taken only
// once the result register has drained. Reset: rst clears control; a clearing pass then
// zeroes the cells with input ready held low. Config writes are taken at any time.
// Depends on tcb_pkg, tcb_channels, tcb_front and tcb_back.
`default_nettype none

module text_console_buffer_core #(
  parameter int ROW_WIDTH = 80,
  parameter int ROWS      = 25
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  tcb_in_if.sink     in_word,
  tcb_out_if.source  out_word
);

  logic             q_valid;
  logic             q_pop;
  logic             filling;
  tcb_pkg::tcb_op_t q_head;

  tcb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .hold      (filling),
    .in_word   (in_word),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  tcb_back #(
    .ROW_WIDTH (ROW_WIDTH),
    .ROWS      (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .filling  (filling),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

/* src/tcb_checker.sv */
// Port-level checks for text_console_buffer_core, attached by bind.
// Depends on the top level's ports only.
`default_nettype none

module tcb_checker #(
  parameter int ROW_WIDTH = 80,
  parameter int ROWS      = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] cursor_index,
  input wire logic        scrolled,
  input wire logic        submitted
);

  localparam int NCELLS = ROWS * ROW_WIDTH;

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during reset clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_index) < 32'(NCELLS)))
    else $error("cursor beyond grid");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> (cursor_index == 11'(NCELLS - ROW_WIDTH)) && !submitted)
    else $error("scroll left cursor off last row start");

  a_submit_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && submitted |-> (cursor_index == 11'd0))
    else $error("submit left cursor nonzero");

endmodule

bind text_console_buffer_core tcb_checker #(
  .ROW_WIDTH (ROW_WIDTH),
  .ROWS      (ROWS)
) u_tcb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .cursor_index (out_word.cursor_index),
  .scrolled     (out_word.scrolled),
  .submitted    (out_word.submitted)
);

`default_nettype wire
